>>> src/assert_macros.svh
// Assertion macros used by the top level of the timer wheel.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Expression must hold on every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

>>> src/ptw_pkg.sv
// Types and constants of the periodic timer wheel.
`default_nettype none

package ptw_pkg;

   localparam int PERIOD_W     = 16;
   localparam int ID_W         = 4;
   localparam int CMD_W        = 2;
   localparam int KIND_W       = 3;
   localparam int ROUNDS_W     = 13;
   localparam int RESULT_LIMIT = 16;
   localparam int CNT_W        = 5;

   localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = 13'd8191;

   // command codes
   localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_REGISTERED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UNREGISTERED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXPIRED      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NO_EXPIRY    = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to cells
   typedef struct packed {
      logic                wr;
      logic                clr;
      logic                shift;
      logic [ID_W-1:0]     id;
      logic [ROUNDS_W-1:0] q;
   } cell_ctl_type;

   // cell to controller
   typedef struct packed {
      logic tok;
      logic expire;
   } cell_sts_type;

endpackage

`default_nettype wire

>>> src/ptw_divider.sv
// Division of a period by the wheel size through reciprocal multiplication.
`default_nettype none

module ptw_divider #(
   parameter int WHEEL_SLOTS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ptw_pkg::PERIOD_W-1:0]      dividend,
   output logic                                   done,
   output logic [ptw_pkg::ROUNDS_W-1:0]           quotient,
   output logic [$clog2(WHEEL_SLOTS)-1:0]         remainder
);

   localparam int SLW   = $clog2(WHEEL_SLOTS);
   localparam int SHIFT = ptw_pkg::PERIOD_W + SLW;
   localparam int MW    = ptw_pkg::PERIOD_W + 2;
   localparam int PW    = ptw_pkg::PERIOD_W + MW;
   localparam int QW    = ptw_pkg::PERIOD_W - SLW + 1;
   localparam int BW    = ptw_pkg::PERIOD_W + 2;
   localparam logic [MW-1:0] RECIP_C   = MW'((64'd1 << SHIFT) / WHEEL_SLOTS);
   localparam logic [BW-1:0] DIVISOR_C = BW'(WHEEL_SLOTS);

   logic                         s1_ff, s1_in;
   logic                         s2_ff, s2_in;
   logic                         done_ff, done_in;
   logic [ptw_pkg::PERIOD_W-1:0] dvd_ff, dvd_in;
   logic [QW-1:0]                est_ff, est_in;
   logic [QW-1:0]                quo_ff, quo_in;
   logic [SLW-1:0]               rem_ff, rem_in;
   logic [PW-1:0]                prod;
   logic [BW-1:0]                back;
   logic [BW-1:0]                diff;

   // stage one holds the period, stage two estimates, stage three corrects by one
   always_comb begin
      s1_in   = start;
      s2_in   = s1_ff;
      done_in = s2_ff;
      dvd_in  = start ? dividend : dvd_ff;
      prod    = PW'(dvd_ff) * PW'(RECIP_C);
      est_in  = prod[SHIFT+QW-1:SHIFT];
      back    = BW'(est_ff) * DIVISOR_C;
      diff    = BW'(dvd_ff) - back;
      if (diff >= DIVISOR_C) begin
         quo_in = est_ff + QW'(1);
         rem_in = SLW'(diff - DIVISOR_C);
      end else begin
         quo_in = est_ff;
         rem_in = SLW'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      est_ff <= est_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // rounds saturate at the top of their field
   always_comb begin
      if (32'(quo_ff) > 32'(ptw_pkg::ROUNDS_MAX)) begin
         quotient = ptw_pkg::ROUNDS_MAX;
      end else begin
         quotient = ptw_pkg::ROUNDS_W'(quo_ff);
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> src/ptw_cell.sv
// One timer entry of the wheel, with its place in the scan token chain.
`default_nettype none

module ptw_cell #(
   parameter int WHEEL_SLOTS = 8,
   parameter int CELL_ID     = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptw_pkg::cell_ctl_type         ctl,
   input  wire logic [$clog2(WHEEL_SLOTS)-1:0] r_bus,
   input  wire logic [$clog2(WHEEL_SLOTS)-1:0] cur,
   input  wire logic                          tok_in,
   output ptw_pkg::cell_sts_type              sts
);

   localparam int SLW = $clog2(WHEEL_SLOTS);
   localparam logic [SLW:0] SLOTS_C = (SLW+1)'(WHEEL_SLOTS);

   logic                         valid_ff, valid_in;
   logic                         tok_ff, tok_next_in;
   logic [ptw_pkg::ROUNDS_W-1:0] q_ff, q_in;
   logic [ptw_pkg::ROUNDS_W-1:0] rounds_ff, rounds_in;
   logic [SLW-1:0]               r_ff, r_in;
   logic [SLW-1:0]               slot_ff, slot_in;
   logic                         match;
   logic                         in_slot;
   logic [SLW-1:0]               radd;
   logic [SLW:0]                 sum;
   logic [SLW-1:0]               wrap_slot;

   // target slot: current slot plus period remainder, modulo wheel size
   always_comb begin
      match   = (32'(ctl.id) == CELL_ID);
      in_slot = valid_ff && (slot_ff == cur);
      radd    = ctl.wr ? r_bus : r_ff;
      sum     = {1'b0, cur} + {1'b0, radd};
      if (sum >= SLOTS_C) begin
         wrap_slot = SLW'(sum - SLOTS_C);
      end else begin
         wrap_slot = SLW'(sum);
      end
   end

   // entry update: write, clear, or scan when holding the token
   always_comb begin
      valid_in    = valid_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      rounds_in   = rounds_ff;
      slot_in     = slot_ff;
      tok_next_in = ctl.shift ? tok_in : tok_ff;
      if (ctl.wr && match) begin
         valid_in  = 1'b1;
         q_in      = ctl.q;
         r_in      = r_bus;
         rounds_in = ctl.q;
         slot_in   = wrap_slot;
      end else if (ctl.clr && match) begin
         valid_in = 1'b0;
      end else if (ctl.shift && tok_ff && in_slot) begin
         if (rounds_ff == '0) begin
            rounds_in = q_ff;
            slot_in   = wrap_slot;
         end else begin
            rounds_in = rounds_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_next_in;
      end
      q_ff      <= q_in;
      r_ff      <= r_in;
      rounds_ff <= rounds_in;
      slot_ff   <= slot_in;
   end

   assign sts.tok    = tok_ff;
   assign sts.expire = tok_ff && in_slot && (rounds_ff == '0);

endmodule

`default_nettype wire

>>> src/periodic_timer_wheel_core.sv
// Top level of the periodic timer wheel: controller, divider and cell chain.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | command, timer_id, period
//   rsp     | out       | rsp_tvalid/rsp_tready | kind, expired_id; tlast = last
//
// Unregister, rejected register: result valid in the cycle after the transaction.
// Register: result valid after period capture, reciprocal multiply,
// remainder correction, then the write into the cell.
// Tick: result valid once the scan token has walked the chain, one cell per
// cycle while the result side does not stall.
// Reset is synchronous; entry valid bits clear at once, no clearing pass.
// The next input is taken once the block is idle and the output register is
// empty or being emptied.
`default_nettype none

`include "assert_macros.svh"

module periodic_timer_wheel_core #(
   parameter int WHEEL_SLOTS = 8,
   parameter int MAX_TIMERS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // command[1:0], timer_id[5:2], period[21:6]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // kind[2:0], expired_id[6:3]
   output logic             rsp_tlast
);

   localparam int SLW = $clog2(WHEEL_SLOTS);
   localparam int IXW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

   ptw_pkg::state_type                 state_ff, state_in;
   logic [SLW-1:0]                     cur_ff, cur_in;
   logic [IXW-1:0]                     idx_ff, idx_in;
   logic [ptw_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic                               pend_valid_ff, pend_valid_in;
   logic [ptw_pkg::ID_W-1:0]           pend_id_ff, pend_id_in;
   logic [ptw_pkg::ID_W-1:0]           reg_id_ff, reg_id_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ptw_pkg::KIND_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic [ptw_pkg::ID_W-1:0]           rsp_id_ff, rsp_id_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [ptw_pkg::CMD_W-1:0]          req_cmd;
   logic [ptw_pkg::ID_W-1:0]           req_id;
   logic [ptw_pkg::PERIOD_W-1:0]       req_period;
   logic                               req_acc;
   logic                               out_free;
   logic                               div_start;
   logic                               div_done;
   logic [ptw_pkg::ROUNDS_W-1:0]       div_q;
   logic [SLW-1:0]                     div_r;
   logic                               start_tick;
   logic                               hit;
   logic                               report;
   logic                               stall;
   logic                               busy_tick;
   ptw_pkg::cell_ctl_type              ctl;
   ptw_pkg::cell_sts_type              sts [MAX_TIMERS];
   logic [MAX_TIMERS-1:0]              tok_vec;
   logic [MAX_TIMERS-1:0]              exp_vec;

   assign req_cmd    = req_tdata[1:0];
   assign req_id     = req_tdata[5:2];
   assign req_period = req_tdata[21:6];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ptw_pkg::ST_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;

   // period divided by the wheel size: rounds and slot offset
   ptw_divider #(
      .WHEEL_SLOTS(WHEEL_SLOTS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_period),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // chain of timer cells, token enters cell 0 at a tick
   for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
      logic tok_prev;
      if (g == 0) begin : g_head
         assign tok_prev = start_tick;
      end else begin : g_link
         assign tok_prev = sts[g-1].tok;
      end
      ptw_cell #(
         .WHEEL_SLOTS(WHEEL_SLOTS),
         .CELL_ID    (g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .r_bus  (div_r),
         .cur    (cur_ff),
         .tok_in (tok_prev),
         .sts    (sts[g])
      );
      assign tok_vec[g] = sts[g].tok;
      assign exp_vec[g] = sts[g].expire;
   end

   // only the token holder can flag an expiry
   assign hit    = |exp_vec;
   assign report = hit && (cnt_ff < ptw_pkg::CNT_W'(ptw_pkg::RESULT_LIMIT));
   assign stall  = report && pend_valid_ff && !out_free;

   assign busy_tick = (state_ff == ptw_pkg::ST_SCAN) || (state_ff == ptw_pkg::ST_FINISH);

   // controller: next state, cell control and result loading
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      reg_id_in     = reg_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      start_tick    = 1'b0;
      ctl.wr        = 1'b0;
      ctl.clr       = 1'b0;
      ctl.shift     = 1'b0;
      ctl.id        = (state_ff == ptw_pkg::ST_DIV) ? reg_id_ff : req_id;
      ctl.q         = div_q;

      case (state_ff)
         ptw_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (req_cmd)
                  ptw_pkg::CMD_REGISTER: begin
                     if (req_period == '0 || 32'(req_id) >= MAX_TIMERS) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = ptw_pkg::KIND_REJECTED;
                        rsp_id_in    = req_id;
                        rsp_last_in  = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        reg_id_in = req_id;
                        state_in  = ptw_pkg::ST_DIV;
                     end
                  end
                  ptw_pkg::CMD_UNREGISTER: begin
                     ctl.clr      = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ptw_pkg::KIND_UNREGISTERED;
                     rsp_id_in    = req_id;
                     rsp_last_in  = 1'b1;
                  end
                  ptw_pkg::CMD_TICK: begin
                     start_tick    = 1'b1;
                     ctl.shift     = 1'b1;
                     cur_in        = (cur_ff == SLW'(WHEEL_SLOTS - 1)) ? '0 : cur_ff + 1'b1;
                     idx_in        = '0;
                     cnt_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ptw_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ptw_pkg::ST_DIV: begin
            // output register is empty here: nothing was loaded since accept
            if (div_done) begin
               ctl.wr       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = ptw_pkg::KIND_REGISTERED;
               rsp_id_in    = reg_id_ff;
               rsp_last_in  = 1'b1;
               state_in     = ptw_pkg::ST_IDLE;
            end
         end
         ptw_pkg::ST_SCAN: begin
            if (!stall) begin
               ctl.shift = 1'b1;
               if (report) begin
                  // the held expiry is not the last one: send it on
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ptw_pkg::KIND_EXPIRED;
                     rsp_id_in    = pend_id_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = ptw_pkg::ID_W'(idx_ff);
                  cnt_in        = cnt_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == IXW'(MAX_TIMERS - 1)) begin
                  state_in = ptw_pkg::ST_FINISH;
               end
            end
         end
         ptw_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_kind_in = ptw_pkg::KIND_EXPIRED;
                  rsp_id_in   = pend_id_ff;
               end else begin
                  rsp_kind_in = ptw_pkg::KIND_NO_EXPIRY;
                  rsp_id_in   = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = ptw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptw_pkg::ST_IDLE;
         cur_ff        <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_id_ff  <= pend_id_in;
      reg_id_ff   <= reg_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_id_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks on the scan token, the held expiry and the expiry count
   `ASSERT_ALWAYS(a_tok_onehot0, clock, reset, $onehot0(tok_vec))
   `ASSERT_IMPLY(a_tok_at_idx, clock, reset, state_ff == ptw_pkg::ST_SCAN, tok_vec[idx_ff])
   `ASSERT_IMPLY(a_pend_scope, clock, reset, pend_valid_ff, busy_tick)
   `ASSERT_ALWAYS(a_cnt_limit, clock, reset, cnt_ff <= ptw_pkg::CNT_W'(ptw_pkg::RESULT_LIMIT))

endmodule

`default_nettype wire
